// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/bmhq_pkg.sv
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int KEY_W  = 32;
  localparam int NODE_W = 13;  // heap node ids, 1-based, up to the largest capacity
  localparam int LVL_W  = 4;   // heap level numbers

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // token kinds walking down the level chain
  localparam logic K_INS = 1'b0;
  localparam logic K_DEL = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;

  // Token handed from one level to the next.
  // insert: node is the path node at the receiving level.
  // remove: node is the hole at the level above the receiver.
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] pos1;  // insert target id
    logic [LVL_W-1:0]  tl;    // insert target level
    logic [NODE_W-1:0] cnt;   // entries stored after a remove
    key_t              key;
  } hq_tok_t;

  // Write into one heap node of a level.
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] node;
    key_t              data;
  } hq_wr_t;

  // Read of the last stored entry before a remove.
  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  lvl;
    logic [NODE_W-1:0] pos;
  } hq_ld_t;

endpackage

// File: rtl/bmhq_cell.sv
`timescale 1ns / 1ps

// One heap level: stores its nodes as left/right sibling pairs and moves a
// token one level per cycle.
module bmhq_cell import bmhq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int LEVEL    = 1
) (
  input  logic    clk,
  input  logic    rst,
  input  hq_tok_t tok_in,
  input  hq_ld_t  ld,
  input  hq_wr_t  wr_in,
  output hq_tok_t tok_out,
  output hq_wr_t  wr_up,
  output logic    done,
  output key_t    rd_even,
  output key_t    rd_odd
);

  localparam int NL      = $clog2(CAPACITY + 1);
  localparam int BASE    = 1 << LEVEL;
  localparam int TOP_POS = (2 * BASE - 1 < CAPACITY) ? 2 * BASE - 1 : CAPACITY;
  localparam int ROWS    = (TOP_POS - BASE) / 2 + 1;
  localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam bit IS_LAST = (LEVEL == NL - 1);
  localparam logic [NODE_W-1:0] HALF_BASE = NODE_W'(BASE / 2);
  localparam logic [NODE_W-1:0] ROWS_N    = NODE_W'(ROWS);
  localparam logic [LVL_W-1:0]  MY_LVL    = LVL_W'(LEVEL);

  key_t even_mem [ROWS];
  key_t odd_mem  [ROWS];

  hq_tok_t           tok_q;
  hq_wr_t            loc_wr;
  hq_wr_t            wr_sel;
  logic              rd_en;
  logic [NODE_W-1:0] rd_row;
  logic [NODE_W-1:0] wr_row;
  logic [LVL_W-1:0]  shamt;
  logic [NODE_W-1:0] pshift;
  logic [NODE_W:0]   c_left;
  logic [NODE_W:0]   c_right;
  logic [NODE_W:0]   c_best;
  logic [NODE_W:0]   cnt_ext;
  logic              l_ok;
  logic              r_ok;
  logic              r_sel;
  logic              move;
  key_t              best;
  key_t              cur;

  function automatic logic [NODE_W-1:0] row_of(input logic [NODE_W-1:0] node);
    return (node >> 1) - HALF_BASE;
  endfunction

  // read row follows the incoming token, else this level's last-entry load
  always_comb begin
    rd_en  = 1'b0;
    rd_row = '0;
    if (tok_in.valid) begin
      rd_en  = 1'b1;
      rd_row = (tok_in.kind == K_DEL) ? tok_in.node - HALF_BASE : row_of(tok_in.node);
    end else if (ld.en && ld.lvl == MY_LVL) begin
      rd_en  = 1'b1;
      rd_row = row_of(ld.pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en && rd_row < ROWS_N) begin
      rd_even <= even_mem[rd_row[RW-1:0]];
      rd_odd  <= odd_mem[rd_row[RW-1:0]];
    end
  end

  assign wr_sel = wr_in.en ? wr_in : loc_wr;
  assign wr_row = row_of(wr_sel.node);

  always_ff @(posedge clk) begin
    if (wr_sel.en) begin
      if (wr_sel.node[0]) begin
        odd_mem[wr_row[RW-1:0]] <= wr_sel.data;
      end else begin
        even_mem[wr_row[RW-1:0]] <= wr_sel.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_in;
    end
  end

  assign shamt   = tok_q.tl - MY_LVL - LVL_W'(1);
  assign pshift  = tok_q.pos1 >> shamt;
  assign cur     = tok_q.node[0] ? rd_odd : rd_even;
  assign c_left  = {tok_q.node, 1'b0};
  assign c_right = {tok_q.node, 1'b1};
  assign cnt_ext = {1'b0, tok_q.cnt};
  assign l_ok    = (c_left <= cnt_ext);
  assign r_ok    = (c_right <= cnt_ext);
  assign r_sel   = r_ok && (rd_odd > rd_even);
  assign best    = r_sel ? rd_odd : rd_even;
  assign c_best  = r_sel ? c_right : c_left;
  assign move    = l_ok && (best > tok_q.key);

  always_comb begin
    tok_out = '0;
    wr_up   = '0;
    loc_wr  = '0;
    done    = 1'b0;
    if (tok_q.valid && tok_q.kind == K_INS) begin
      if (tok_q.tl == MY_LVL) begin
        // target slot is empty: drop the carried key in
        loc_wr.en   = 1'b1;
        loc_wr.node = tok_q.node;
        loc_wr.data = tok_q.key;
        done        = 1'b1;
      end else begin
        tok_out      = tok_q;
        tok_out.node = {tok_q.node[NODE_W-2:0], pshift[0]};
        if (cur < tok_q.key) begin
          // keep the larger key here, push the smaller one on
          loc_wr.en   = 1'b1;
          loc_wr.node = tok_q.node;
          loc_wr.data = tok_q.key;
          tok_out.key = cur;
        end
      end
    end else if (tok_q.valid && tok_q.kind == K_DEL) begin
      wr_up.en   = 1'b1;
      wr_up.node = tok_q.node;
      if (move) begin
        wr_up.data = best;
        if (IS_LAST) begin
          loc_wr.en   = 1'b1;
          loc_wr.node = c_best[NODE_W-1:0];
          loc_wr.data = tok_q.key;
          done        = 1'b1;
        end else begin
          tok_out      = tok_q;
          tok_out.node = c_best[NODE_W-1:0];
        end
      end else begin
        wr_up.data = tok_q.key;
        done       = 1'b1;
      end
    end
  end

endmodule

// File: rtl/binary_max_heap_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         start, taken when !busy   operation, key
// result    out        done, one-cycle strobe    value, status, count, is_empty
//
// Peek, refused requests, the unused code, an insert into an empty queue and
// a remove of the only entry answer in the cycle after the request. Any other
// insert launches its token and waits until the level of the new slot is done;
// a remove first loads the last entry, then launches it and waits likewise.
// Reset (rst, synchronous) empties the queue; heap contents are not cleared.
// The receiver cannot stall; a new request may be taken with the strobe.
//
// Level 0 (the root) sits in the controller; every deeper level is a cell of
// its own holding its nodes in sibling-pair memories, and the chain moves one
// level per cycle. Insert walks top-down along the path to the new slot,
// keeping the larger key at each node and carrying the smaller one on. Remove
// first reads the last entry, puts it at the root and sifts it down, each cell
// comparing its two children of the hole.
module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  key_t        key,
  output logic        done,
  output key_t        value,
  output logic [1:0]  status,
  output logic [6:0]  count,
  output logic        is_empty
);

  localparam int NL = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     cnt;
  logic [1:0]        op_q;
  key_t              key_q;
  key_t              root;
  key_t              pop_q;
  logic [NODE_W-1:0] pos1_q;
  logic [LVL_W-1:0]  lvl_q;
  key_t              last_key;
  logic [NODE_W-1:0] pos1_sh;
  hq_tok_t           tok_h;
  hq_ld_t            ld;
  logic [NL-1:1]     done_v;

  hq_tok_t tok     [1:NL-1];
  hq_wr_t  uw      [1:NL-1];
  key_t    rd_even [1:NL-1];
  key_t    rd_odd  [1:NL-1];

  function automatic logic [LVL_W-1:0] msb_of(input logic [NODE_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [6:0] count7(input logic [CW-1:0] c);
    logic [CW+6:0] e;
    e = {7'b0, c};
    return e[6:0];
  endfunction

  assign busy = (state != S_IDLE);

  // fetch the last entry ahead of a remove
  assign ld.en  = (state == S_LOAD);
  assign ld.lvl = lvl_q;
  assign ld.pos = pos1_q;

  always_comb begin
    last_key = rd_even[1];
    for (int l = 1; l < NL; l++) begin
      if (lvl_q == LVL_W'(l)) last_key = pos1_q[0] ? rd_odd[l] : rd_even[l];
    end
  end

  assign pos1_sh = pos1_q >> (lvl_q - LVL_W'(1));

  // launch a token into level 1
  always_comb begin
    tok_h = '0;
    if (state == S_INS) begin
      tok_h.valid = 1'b1;
      tok_h.kind  = K_INS;
      tok_h.node  = NODE_W'(2) | {{(NODE_W-1){1'b0}}, pos1_sh[0]};
      tok_h.pos1  = pos1_q;
      tok_h.tl    = lvl_q;
      tok_h.key   = (root < key_q) ? root : key_q;
    end else if (state == S_POP) begin
      tok_h.valid = 1'b1;
      tok_h.kind  = K_DEL;
      tok_h.node  = NODE_W'(1);
      tok_h.cnt   = NODE_W'(cnt - CW'(1));
      tok_h.key   = last_key;
    end
  end

  assign tok[1] = tok_h;

  for (genvar l = 1; l < NL; l++) begin : g_lvl
    if (l < NL - 1) begin : g_mid
      bmhq_cell #(.CAPACITY(CAPACITY), .LEVEL(l)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok[l]),
        .ld      (ld),
        .wr_in   (uw[l+1]),
        .tok_out (tok[l+1]),
        .wr_up   (uw[l]),
        .done    (done_v[l]),
        .rd_even (rd_even[l]),
        .rd_odd  (rd_odd[l])
      );
    end else begin : g_end
      bmhq_cell #(.CAPACITY(CAPACITY), .LEVEL(l)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok[l]),
        .ld      (ld),
        .wr_in   ('0),
        .tok_out (),
        .wr_up   (uw[l]),
        .done    (done_v[l]),
        .rd_even (rd_even[l]),
        .rd_odd  (rd_odd[l])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      // level 1 hands the root its new key during a sift-down
      if (uw[1].en) root <= uw[1].data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= operation;
            key_q <= key;
            unique case (operation)
              OP_INSERT: begin
                if (cnt >= CW'(CAPACITY)) begin
                  value    <= '0;
                  status   <= ST_FULL;
                  count    <= count7(cnt);
                  is_empty <= (cnt == '0);
                  done     <= 1'b1;
                end else if (cnt == '0) begin
                  root     <= key;
                  cnt      <= CW'(1);
                  value    <= '0;
                  status   <= ST_OK;
                  count    <= count7(CW'(1));
                  is_empty <= 1'b0;
                  done     <= 1'b1;
                end else begin
                  pos1_q <= NODE_W'(cnt) + NODE_W'(1);
                  lvl_q  <= msb_of(NODE_W'(cnt) + NODE_W'(1));
                  state  <= S_INS;
                end
              end
              OP_REMOVE: begin
                if (cnt == '0) begin
                  value    <= '0;
                  status   <= ST_EMPTY;
                  count    <= count7(cnt);
                  is_empty <= 1'b1;
                  done     <= 1'b1;
                end else if (cnt == CW'(1)) begin
                  cnt      <= '0;
                  value    <= root;
                  status   <= ST_OK;
                  count    <= count7('0);
                  is_empty <= 1'b1;
                  done     <= 1'b1;
                end else begin
                  pos1_q <= NODE_W'(cnt);
                  lvl_q  <= msb_of(NODE_W'(cnt));
                  state  <= S_LOAD;
                end
              end
              OP_PEEK: begin
                value    <= (cnt == '0) ? '0 : root;
                status   <= (cnt == '0) ? ST_EMPTY : ST_OK;
                count    <= count7(cnt);
                is_empty <= (cnt == '0);
                done     <= 1'b1;
              end
              default: begin
                // unused code: answer ok, change nothing
                value    <= '0;
                status   <= ST_OK;
                count    <= count7(cnt);
                is_empty <= (cnt == '0);
                done     <= 1'b1;
              end
            endcase
          end
        end
        S_INS: begin
          // keep the larger key at the root, carry the smaller one down
          if (root < key_q) root <= key_q;
          cnt   <= cnt + CW'(1);
          state <= S_WAIT;
        end
        S_LOAD: begin
          state <= S_POP;
        end
        S_POP: begin
          // hold the old root as the answer, shrink, start the sift-down
          pop_q <= root;
          cnt   <= cnt - CW'(1);
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (|done_v) begin
            value    <= (op_q == OP_REMOVE) ? pop_q : '0;
            status   <= ST_OK;
            count    <= count7(cnt);
            is_empty <= (cnt == '0);
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  // a single token is in the chain, so at most one level finishes at a time
  `ASSERT_IMPLY(a_one_level_done, clk, rst, 1'b1, $onehot0(done_v))
  // levels only finish while the controller waits on them
  `ASSERT_IMPLY(a_done_in_wait, clk, rst, (|done_v), (state == S_WAIT))
  // a peek answers in the next cycle
  `ASSERT_NEXT(a_peek_next, clk, rst, (start && !busy && operation == OP_PEEK), done)

endmodule

// File: bench/binary_max_heap_queue_test.sv
`timescale 1ns / 1ps

// Bench for the heap-based max-priority queue. A software heap tracks every
// accepted request and predicts value, status, count and is_empty for it;
// each done strobe is checked against the oldest prediction.
module binary_max_heap_queue_test;
  import bmhq_pkg::*;

  localparam int DEPTH = 64;
  localparam int ITEMS = 1800;
  localparam int STALL_LIMIT = 2000;  // cycles with no request and no result
  localparam int TAIL_CYCLES = 16;    // longer than the deepest remove
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    key_t       value;
    logic [1:0] status;
    logic [6:0] count;
    logic       is_empty;
  } heap_result_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  // Software heap: mirrors the stored keys and queues one predicted result
  // per accepted request.
  class heap_scoreboard;
    key_t         slots[DEPTH];
    int unsigned  fill;
    heap_result_t awaited[$];
    int unsigned  errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void note_request(logic [1:0] op, key_t k);
      heap_result_t r;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  left;
      int unsigned  best;
      key_t         t;
      r.value = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // append, then climb while larger than the parent
            slots[fill] = k;
            pos = fill;
            while (pos > 0) begin
              parent = (pos - 1) / 2;
              if (!(slots[parent] < slots[pos])) break;
              t = slots[parent];
              slots[parent] = slots[pos];
              slots[pos] = t;
              pos = parent;
            end
            fill++;
          end
        end
        OP_REMOVE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // take the root, move the last key up and sink it
            r.value = slots[0];
            fill--;
            slots[0] = slots[fill];
            pos = 0;
            while (1) begin
              left = 2 * pos + 1;
              if (left >= fill) break;
              best = left;
              // on a tie the left child wins
              if (left + 1 < fill && slots[left + 1] > slots[left]) best = left + 1;
              if (!(slots[best] > slots[pos])) break;
              t = slots[best];
              slots[best] = slots[pos];
              slots[pos] = t;
              pos = best;
            end
          end
        end
        OP_PEEK: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.value = slots[0];
        end
        default: begin
          // unused code: nothing changes
        end
      endcase
      r.count = 7'(fill);
      r.is_empty = (fill == 0);
      awaited.push_back(r);
    endfunction

    function void check_result(key_t v, logic [1:0] st, logic [6:0] cnt, logic emp);
      heap_result_t r;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: value %0d status %0d count %0d",
                 $time, v, st, cnt);
        return;
      end
      r = awaited.pop_front();
      if (v !== r.value) begin
        errors++;
        $display("%0t: value expected %0d actual %0d", $time, r.value, v);
      end
      if (st !== r.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
      end
      if (cnt !== r.count) begin
        errors++;
        $display("%0t: count expected %0d actual %0d", $time, r.count, cnt);
      end
      if (emp !== r.is_empty) begin
        errors++;
        $display("%0t: is_empty expected %0b actual %0b", $time, r.is_empty, emp);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] operation;
  key_t       key;
  logic       done;
  key_t       value;
  logic [1:0] status;
  logic [6:0] count;
  logic       is_empty;

  heap_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;

  binary_max_heap_queue #(.CAPACITY(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .key(key),
    .done(done),
    .value(value),
    .status(status),
    .count(count),
    .is_empty(is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample at the rising edge, before the edge's updates land. Check the
  // strobe first so a request taken in the strobe cycle queues behind it.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(value, status, count, is_empty);
      if (start && !busy) sb.note_request(operation, key);
    end
  end

  // Watchdog: end the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mix of extremes, tiny values (lots of ties) and full-range keys.
  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0: return key_t'(32'h7fffffff);
      1: return key_t'(32'h80000000);
      2, 3, 4: return key_t'($urandom_range(0, 8)) - 4;
      default: return key_t'($urandom);
    endcase
  endfunction

  // Draw an operation; a few percent are the unused code as noise.
  function automatic logic [1:0] pick_op(int unsigned ins_pct, int unsigned rem_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNUSED;
    if (r < 3 + ins_pct) return OP_INSERT;
    if (r < 3 + ins_pct + rem_pct) return OP_REMOVE;
    return OP_PEEK;
  endfunction

  // Present one request, hold it until taken, then idle per the burst pattern.
  task automatic push_request(input logic [1:0] op, input key_t k);
    int unsigned gap;
    start <= 1'b1;
    operation <= op;
    key <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long back-to-back stretch
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(0, 9);
    end
  endtask

  initial begin
    phase_t      phase;
    int unsigned n;
    rst <= 1'b1;
    start <= 1'b0;
    operation <= OP_INSERT;
    key <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty errors, unused code, extreme keys, ties, full drain.
    push_request(OP_PEEK, '0);
    push_request(OP_REMOVE, key_t'(32'hffffffff));
    push_request(OP_UNUSED, key_t'(32'h12345678));
    push_request(OP_INSERT, key_t'(32'h7fffffff));
    push_request(OP_INSERT, key_t'(32'h80000000));
    push_request(OP_PEEK, '0);
    push_request(OP_INSERT, '0);
    push_request(OP_INSERT, -1);
    push_request(OP_INSERT, 1);
    push_request(OP_INSERT, 5);
    push_request(OP_INSERT, 5);
    push_request(OP_INSERT, 5);
    push_request(OP_PEEK, key_t'(32'hffffffff));
    repeat (8) push_request(OP_REMOVE, '0);
    push_request(OP_REMOVE, '0);
    push_request(OP_INSERT, key_t'(32'h80000000));
    push_request(OP_UNUSED, key_t'(32'hffffffff));
    push_request(OP_REMOVE, '0);

    // Random: fill to the top and past it, drain to the bottom and past
    // it, and mixed stretches in between.
    while (sent < ITEMS) begin
      phase = phase_t'($urandom_range(0, 2));
      case (phase)
        PH_FILL: begin
          while (sb.fill < DEPTH) push_request(pick_op(85, 8), pick_key());
          repeat ($urandom_range(1, 4)) push_request(OP_INSERT, pick_key());
          push_request(OP_PEEK, pick_key());
        end
        PH_DRAIN: begin
          while (sb.fill > 0) push_request(pick_op(6, 85), pick_key());
          repeat ($urandom_range(1, 3)) push_request(pick_op(0, 60), pick_key());
        end
        default: begin
          n = $urandom_range(20, 120);
          repeat (n) push_request(pick_op(45, 38), pick_key());
        end
      endcase
    end

    // Drop start, drain the outstanding results, then watch a quiet tail.
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_cell.sv
rtl/binary_max_heap_queue.sv
bench/binary_max_heap_queue_test.sv
